// ----- hdl/bpra_pkg.sv -----
// shared constants, codes and types of the bitmap page run allocator
`timescale 1ns / 1ps

package bpra_pkg;

  localparam int unsigned MAX_PAGES = 4096;
  localparam int unsigned MAX_RUN   = 256;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned WORDS     = MAX_PAGES / WORD_W;
  localparam int unsigned WORD_AW   = $clog2(WORDS);
  localparam int unsigned BIT_AW    = $clog2(WORD_W);
  localparam int unsigned PAGE_AW   = $clog2(MAX_PAGES);
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned RUN_W     = 8;
  localparam int unsigned CFG_W     = 13;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BAD     = 2'd2
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic               rd_en;
    logic [WORD_AW-1:0] rd_addr;
    logic               wr_en;
    logic [WORD_AW-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;
  } ram_req_t;

  typedef struct packed {
    logic              found;
    logic [BIT_AW-1:0] pos;
    logic [RUN_W-1:0]  run_out;
  } scan_res_t;

endpackage

// ----- hdl/bpra_bitmap_ram.sv -----
// bitmap word memory with per-word written flags; unwritten words read as all used
`timescale 1ns / 1ps

module bpra_bitmap_ram (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpra_pkg::ram_req_t            req_i,
  output logic [bpra_pkg::WORD_W-1:0]   rd_word_o
);
  import bpra_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  written_q;
  logic [WORD_W-1:0] rd_data_q;
  logic              rd_written_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        written_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_written_q <= written_q[req_i.rd_addr];
      end
    end
  end

  assign rd_word_o = rd_written_q ? rd_data_q : '1;

endmodule

// ----- hdl/bpra_word_scan.sv -----
// first-fit run search over one bitmap word, carrying the free run from earlier words
`timescale 1ns / 1ps

module bpra_word_scan (
  input  logic [bpra_pkg::WORD_W-1:0] used_i,
  input  logic [bpra_pkg::RUN_W-1:0]  run_in_i,
  input  logic [bpra_pkg::CNT_W-1:0]  need_i,
  output bpra_pkg::scan_res_t         res_o
);
  import bpra_pkg::*;

  logic [BIT_AW:0] last_used [WORD_W];
  logic [BIT_AW:0] free_len  [WORD_W];
  logic [CNT_W-1:0] run_at   [WORD_W];
  logic [CNT_W-1:0] run_end;

  // per bit position: length of the free stretch ending there, plus carry-in if unbroken
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      last_used[j] = '0;
      for (int k = 0; k <= j; k++) begin
        if (used_i[k]) begin
          last_used[j] = (BIT_AW+1)'(k + 1);
        end
      end
      free_len[j] = (BIT_AW+1)'(j + 1) - last_used[j];
      run_at[j]   = CNT_W'(free_len[j]);
      if (last_used[j] == '0) begin
        run_at[j] = run_at[j] + CNT_W'(run_in_i);
      end
    end
  end

  always_comb begin
    res_o.found = 1'b0;
    res_o.pos   = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (run_at[j] >= need_i) begin
        res_o.found = 1'b1;
        res_o.pos   = BIT_AW'(j);
      end
    end
    run_end       = run_at[WORD_W-1];
    res_o.run_out = run_end[RUN_W-1:0];
  end

endmodule

// ----- hdl/bitmap_page_run_allocator_unit.sv -----
// top level of the bitmap page run allocator: sequencer, config register and result register
`timescale 1ns / 1ps

// Keeps one used/free bit per page (4096 pages, all used after reset) in a 256 x 16
// bitmap memory with a registered read. An allocate searches first fit from
// page 0 for page_count free pages below the configured page count, marks them used
// and returns the first page; a free clears page_count bits from page_index. Counts of
// 0, above 256, above the page count, or frees running past it return status 2 and
// change nothing. One item is in work at a time. An allocate scans bitmap words one
// by one (at most 256, one memory read a cycle), then marks each word of the run
// by a read and a write back (at most 17 words); a free reads and writes back each
// word it touches. Rejected requests go straight to the result state. The result sits
// in an output register, so the next item is taken while it waits. Memory words never
// written read as all used, so no clearing pass follows reset.
module bitmap_page_run_allocator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpra_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [bpra_pkg::PAGE_AW-1:0]  page_index_i,
  input  logic [bpra_pkg::CNT_W-1:0]    page_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [bpra_pkg::PAGE_AW-1:0]  first_page_o
);
  import bpra_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_MARK_RD = 3'd2;
  localparam logic [2:0] S_MARK_WR = 3'd3;
  localparam logic [2:0] S_RESP    = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CFG_W-1:0]   cfg_pages_q;
  logic [CFG_W-1:0]   eff_pages;
  logic [PAGE_AW-1:0] last_page;

  logic [CNT_W-1:0]   need_q, need_d;
  logic [RUN_W-1:0]   run_q, run_d;
  logic [WORD_AW-1:0] cur_q, cur_d;
  logic [WORD_AW-1:0] last_w_q, last_w_d;
  logic [PAGE_AW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic               set_q, set_d;
  logic [1:0]         res_status_q, res_status_d;
  logic [PAGE_AW-1:0] res_first_q, res_first_d;

  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [PAGE_AW-1:0] out_first_q;

  ram_req_t           ram_req;
  logic [WORD_W-1:0]  rd_word;
  logic [WORD_W-1:0]  scan_used;
  logic [WORD_W-1:0]  mark_word;
  scan_res_t          scan_res;

  logic               in_xfer;
  logic               resp_load;
  logic [CFG_W-1:0]   free_end;
  logic [CFG_W-1:0]   alloc_start;
  logic [PAGE_AW-1:0] found_page;

  // clamp of the page count register to the bitmap size
  assign eff_pages = (cfg_pages_q > CFG_W'(MAX_PAGES)) ? CFG_W'(MAX_PAGES) : cfg_pages_q;
  assign last_page = PAGE_AW'(eff_pages - CFG_W'(1));

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign resp_load  = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  assign free_end    = CFG_W'(page_index_i) + CFG_W'(page_count_i);
  assign found_page  = {cur_q, scan_res.pos};
  assign alloc_start = CFG_W'(found_page) + CFG_W'(1) - CFG_W'(need_q);

  bpra_bitmap_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ram_req),
    .rd_word_o (rd_word)
  );

  // pages at or past the page count look used to the search
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      scan_used[b] = rd_word[b] ||
                     ({1'b0, cur_q, BIT_AW'(b)} >= eff_pages);
    end
  end

  bpra_word_scan u_scan (
    .used_i   (scan_used),
    .run_in_i (run_q),
    .need_i   (need_q),
    .res_o    (scan_res)
  );

  // read-modify-write of one word: set or clear the bits inside [lo, hi]
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      if (({cur_q, BIT_AW'(b)} >= lo_q) && ({cur_q, BIT_AW'(b)} <= hi_q)) begin
        mark_word[b] = set_q;
      end else begin
        mark_word[b] = rd_word[b];
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    need_d       = need_q;
    run_d        = run_q;
    cur_d        = cur_q;
    last_w_d     = last_w_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    set_d        = set_q;
    res_status_d = res_status_q;
    res_first_d  = res_first_q;
    ram_req      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          need_d       = page_count_i;
          res_status_d = ST_DONE;
          res_first_d  = '0;
          run_d        = '0;
          if ((page_count_i == '0) || (page_count_i > CNT_W'(MAX_RUN)) ||
              (CFG_W'(page_count_i) > eff_pages)) begin
            res_status_d = ST_BAD;
            state_d      = S_RESP;
          end else if (cmd_i == CMD_ALLOC) begin
            // first word read goes out now, data is there in the scan state
            cur_d           = '0;
            last_w_d        = last_page[PAGE_AW-1:BIT_AW];
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = '0;
            state_d         = S_SCAN;
          end else if (free_end > eff_pages) begin
            res_status_d = ST_BAD;
            state_d      = S_RESP;
          end else begin
            lo_d    = page_index_i;
            hi_d    = PAGE_AW'(free_end - CFG_W'(1));
            set_d   = 1'b0;
            cur_d   = page_index_i[PAGE_AW-1:BIT_AW];
            last_w_d = hi_d[PAGE_AW-1:BIT_AW];
            state_d = S_MARK_RD;
          end
        end
      end

      S_SCAN: begin
        // next word read runs ahead of the decision on this one
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = cur_q + WORD_AW'(1);
        if (scan_res.found) begin
          lo_d        = PAGE_AW'(alloc_start);
          hi_d        = found_page;
          set_d       = 1'b1;
          res_first_d = PAGE_AW'(alloc_start);
          cur_d       = alloc_start[PAGE_AW-1:BIT_AW];
          last_w_d    = cur_q;
          state_d     = S_MARK_RD;
        end else if (cur_q == last_w_q) begin
          res_status_d = ST_NOSPACE;
          state_d      = S_RESP;
        end else begin
          cur_d = cur_q + WORD_AW'(1);
          run_d = scan_res.run_out;
        end
      end

      S_MARK_RD: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = cur_q;
        state_d         = S_MARK_WR;
      end

      S_MARK_WR: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = cur_q;
        ram_req.wr_data = mark_word;
        if (cur_q == last_w_q) begin
          state_d = S_RESP;
        end else begin
          cur_d   = cur_q + WORD_AW'(1);
          state_d = S_MARK_RD;
        end
      end

      S_RESP: begin
        if (resp_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_pages_q <= CFG_W'(MAX_PAGES);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_pages_q <= cfg_wdata_i;
      end
      if (resp_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers of the item in flight
  always_ff @(posedge clk_i) begin
    need_q       <= need_d;
    run_q        <= run_d;
    cur_q        <= cur_d;
    last_w_q     <= last_w_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    set_q        <= set_d;
    res_status_q <= res_status_d;
    res_first_q  <= res_first_d;
    if (resp_load) begin
      out_status_q <= res_status_q;
      out_first_q  <= res_first_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign first_page_o = out_first_q;

endmodule

// ----- tb/sv/bitmap_page_run_allocator_unit_tb.sv -----
// self-checking testbench of the bitmap page run allocator unit
`timescale 1ns / 1ps

module bitmap_page_run_allocator_unit_tb;
  import bpra_pkg::*;

  // slowest run: ~1000 items of a full 256-word scan plus marking, worst stalls
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  typedef struct {
    status_e            status;
    logic [PAGE_AW-1:0] first;
  } alloc_outcome_t;

  // a run handed out by a successful allocate, kept so it can be freed again
  typedef struct {
    int unsigned base;
    int unsigned len;
  } page_run_t;

  // every input is known from time zero
  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata_i  = '0;
  logic               in_valid_i   = 1'b0;
  logic               cmd_i        = 1'b0;
  logic [PAGE_AW-1:0] page_index_i = '0;
  logic [CNT_W-1:0]   page_count_i = '0;
  logic               out_ready_i  = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [1:0]         status_o;
  logic [PAGE_AW-1:0] first_page_o;

  // predictor state: own copy of the bitmap and of the page count register
  bit                 page_used_map [MAX_PAGES];
  logic [CFG_W-1:0]   pages_cfg;
  alloc_outcome_t     outcome_q [$];
  page_run_t          held_runs [$];

  int unsigned        fail_count  = 0;
  int unsigned        cycle_count = 0;
  bit                 quiet_tail  = 1'b0;
  bit                 idle_burst_on = 1'b1;

  bitmap_page_run_allocator_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .page_index_i (page_index_i),
    .page_count_i (page_count_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .first_page_o (first_page_o)
  );

  // 12 ns period
  always #6 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // switch between stretches with idle bursts and stretches without
  initial begin
    forever begin
      repeat ($urandom_range(40, 400)) @(posedge clk_i);
      idle_burst_on = !idle_burst_on;
    end
  end

  // page count actually covered: register value clamped to the bitmap size
  function automatic int unsigned covered_pages();
    return (pages_cfg > MAX_PAGES) ? MAX_PAGES : int'(pages_cfg);
  endfunction

  // first-fit allocate / run free on the shadow bitmap, returns the expected result
  function automatic alloc_outcome_t compute_alloc_result(cmd_e op,
                                                          logic [PAGE_AW-1:0] idx,
                                                          logic [CNT_W-1:0] cnt);
    alloc_outcome_t res;
    int unsigned    span;
    int unsigned    n;
    int unsigned    start;
    int unsigned    run;
    int unsigned    pos;
    int unsigned    i;
    bit             found;
    span       = covered_pages();
    n          = cnt;
    start      = idx;
    res.status = ST_DONE;
    res.first  = '0;
    run        = 0;
    pos        = 0;
    found      = 1'b0;
    if (n == 0 || n > MAX_RUN || n > span) begin
      res.status = ST_BAD;
    end else if (op == CMD_ALLOC) begin
      // scan only inside the covered pages, restart the run at each used page
      for (i = 0; i < span && !found; i++) begin
        if (page_used_map[i]) begin
          run = 0;
        end else begin
          run++;
          if (run == n) begin
            found = 1'b1;
            pos   = i;
          end
        end
      end
      if (found) begin
        start = pos + 1 - n;
        for (i = 0; i < n; i++) page_used_map[start + i] = 1'b1;
        res.first = start[PAGE_AW-1:0];
        held_runs.push_back('{base: start, len: n});
      end else begin
        res.status = ST_NOSPACE;
      end
    end else begin
      // a free that runs past the covered pages is refused whole
      if (start + n > span) begin
        res.status = ST_BAD;
      end else begin
        for (i = 0; i < n; i++) page_used_map[start + i] = 1'b0;
      end
    end
    return res;
  endfunction

  // result side: random ready stalls, sampled on the rising edge by the checker
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (quiet_tail || !idle_burst_on) begin
        out_ready_i = 1'b1;
        hold        = 0;
      end else if (hold > 0) begin
        out_ready_i = 1'b0;
        hold--;
      end else if ($urandom_range(0, 99) < 20) begin
        out_ready_i = 1'b0;
        hold        = $urandom_range(1, 13) - 1;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // every result transfer is matched against the oldest prediction
  always @(posedge clk_i) begin : check_result
    alloc_outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (outcome_q.size() == 0) begin
        $error("unexpected result transfer: status %0d first_page %0d",
               status_o, first_page_o);
        fail_count++;
      end else begin
        want = outcome_q.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          fail_count++;
        end
        if (first_page_o !== want.first) begin
          $error("first_page: expected %0d, actual %0d", want.first, first_page_o);
          fail_count++;
        end
      end
    end
  end

  // one request transfer; valid stays up afterwards so items can go back to back
  task automatic send_item(cmd_e op, logic [PAGE_AW-1:0] idx, logic [CNT_W-1:0] cnt);
    int unsigned gap;
    if (!quiet_tail && idle_burst_on && $urandom_range(0, 99) < 25) begin
      gap = $urandom_range(1, 13);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   = 1'b1;
    cmd_i        = op;
    page_index_i = idx;
    page_count_i = cnt;
    do @(posedge clk_i); while (!in_ready_o);
    outcome_q.push_back(compute_alloc_result(op, idx, cnt));
  endtask

  // stop sending and hold off until every predicted result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write only while the block is idle
  task automatic write_page_count(logic [CFG_W-1:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    pages_cfg   = value;
  endtask

  // release every page below upto, in runs of at most the longest run
  task automatic free_span(int unsigned upto);
    int unsigned base;
    base = 0;
    while (base < upto) begin
      send_item(CMD_FREE, base[PAGE_AW-1:0],
                CNT_W'((upto - base > MAX_RUN) ? MAX_RUN : upto - base));
      base += MAX_RUN;
    end
  endtask

  // run length mostly short, now and then up to the longest run
  function automatic logic [CNT_W-1:0] pick_run_len();
    int unsigned q;
    q = $urandom_range(0, 99);
    if (q < 70) return CNT_W'($urandom_range(1, 8));
    else if (q < 93) return CNT_W'($urandom_range(1, 48));
    return CNT_W'($urandom_range(1, MAX_RUN));
  endfunction

  // mostly allocates and frees of runs that were handed out, some loose frees and noise
  task automatic issue_random_item();
    int unsigned r;
    int unsigned k;
    int unsigned span;
    page_run_t   held;
    r    = $urandom_range(0, 99);
    span = covered_pages();
    if (r < 48) begin
      send_item(CMD_ALLOC, PAGE_AW'($urandom_range(0, MAX_PAGES - 1)), pick_run_len());
    end else if (r < 83 && held_runs.size() > 0) begin
      k    = $urandom_range(0, held_runs.size() - 1);
      held = held_runs[k];
      held_runs.delete(k);
      send_item(CMD_FREE, held.base[PAGE_AW-1:0], held.len[CNT_W-1:0]);
    end else if (r < 94) begin
      // loose free somewhere in the covered pages, may run past the end
      send_item(CMD_FREE, PAGE_AW'($urandom_range(0, (span == 0) ? 0 : span - 1)),
                CNT_W'($urandom_range(1, 32)));
    end else begin
      // noise over the whole field ranges, illegal counts included
      send_item(cmd_e'($urandom_range(0, 1)), PAGE_AW'($urandom_range(0, MAX_PAGES - 1)),
                CNT_W'($urandom_range(0, (1 << CNT_W) - 1)));
    end
    if ($urandom_range(0, 199) == 0) wait_drained();
  endtask

  // field extremes, both commands and every corner of the request checks
  task automatic test_directed();
    send_item(CMD_ALLOC, '0, 9'd1);            // everything used after reset
    send_item(CMD_ALLOC, '0, 9'd0);            // zero count
    send_item(CMD_ALLOC, '0, 9'd257);          // count above the longest run
    send_item(CMD_FREE, '1, 9'd511);
    send_item(CMD_FREE, 12'd4095, 9'd1);       // last page
    send_item(CMD_FREE, 12'd4095, 9'd2);       // free past the end
    send_item(CMD_FREE, '0, 9'd256);
    send_item(CMD_FREE, '0, 9'd3);             // freeing pages already free
    send_item(CMD_ALLOC, '1, 9'd1);            // single page, lands on page 0
    send_item(CMD_ALLOC, '0, 9'd256);          // only 255 free in a row
    send_item(CMD_ALLOC, '0, 9'd255);
    send_item(CMD_ALLOC, '0, 9'd1);            // top page, widest index
    write_page_count(13'd1);
    send_item(CMD_ALLOC, '0, 9'd2);            // larger than the page count
    send_item(CMD_FREE, '0, 9'd1);
    send_item(CMD_ALLOC, '0, 9'd1);
    send_item(CMD_FREE, 12'd1, 9'd1);          // outside the one covered page
    write_page_count(13'd0);                   // nothing covered
    send_item(CMD_ALLOC, '0, 9'd1);
    send_item(CMD_FREE, '0, 9'd1);
    write_page_count(13'h1FFF);                // clamps to the bitmap size
    send_item(CMD_FREE, 12'd4000, 9'd96);
    send_item(CMD_ALLOC, '0, 9'd96);
    write_page_count(13'(MAX_PAGES));
  endtask

  // small map: scans are short, the map fills and drains often
  task automatic test_random_small_map();
    int unsigned i;
    write_page_count(CFG_W'($urandom_range(8, 512)));
    held_runs.delete();
    free_span(covered_pages());
    for (i = 0; i < 350; i++) begin
      issue_random_item();
      if (i == 175) wait_drained();
    end
  endtask

  // full map with a free block low and another somewhere random
  task automatic test_random_full_map();
    int unsigned i;
    int unsigned base;
    write_page_count(CFG_W'(MAX_PAGES));
    held_runs.delete();
    free_span(1024);
    base = $urandom_range(1024, MAX_PAGES - MAX_RUN);
    send_item(CMD_FREE, base[PAGE_AW-1:0], CNT_W'(MAX_RUN));
    for (i = 0; i < 300; i++) issue_random_item();
  endtask

  // page count rewritten between bursts, bitmap kept as it is
  task automatic test_random_resized();
    int unsigned ph;
    int unsigned i;
    for (ph = 0; ph < 5; ph++) begin
      if (ph == 0) write_page_count(13'd1);
      else if (ph == 1) write_page_count(CFG_W'(MAX_PAGES));
      else write_page_count(CFG_W'($urandom_range(1, MAX_PAGES)));
      for (i = 0; i < 50; i++) issue_random_item();
    end
  endtask

  // last part runs with no idling on either side
  task automatic test_quiet_tail();
    int unsigned i;
    wait_drained();
    quiet_tail = 1'b1;
    write_page_count(CFG_W'($urandom_range(64, 1024)));
    for (i = 0; i < 100; i++) issue_random_item();
  endtask

  initial begin
    int unsigned p;
    for (p = 0; p < MAX_PAGES; p++) page_used_map[p] = 1'b1;
    pages_cfg = 13'(MAX_PAGES);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_small_map();
    test_random_full_map();
    test_random_resized();
    test_quiet_tail();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/bpra_pkg.sv
hdl/bpra_bitmap_ram.sv
hdl/bpra_word_scan.sv
hdl/bitmap_page_run_allocator_unit.sv
tb/sv/bitmap_page_run_allocator_unit_tb.sv
